>>> rtl/core/kds_pkg.sv
// shared types, constants and keypad table for the keypad debounce scanner
`default_nettype none

package kds_pkg;

	localparam int SENSE_BITS = 16;
	localparam int CFG_BITS   = 16;
	localparam int CODE_BITS  = 8;
	localparam int INDEX_BITS = 4;
	localparam int CHAR_BITS  = 8;
	localparam int PAD_SIZE   = 4;

	typedef enum logic [0:0] {
		REG_DEBOUNCE    = 1'b0,
		REG_REPEAT_WAIT = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET    = 16'd50;
	localparam logic [CFG_BITS-1:0] REPEAT_WAIT_RESET = 16'd300;

	// candidate key from the priority encoder
	typedef struct packed {
		logic                  found;
		logic [CODE_BITS-1:0]  code;
		logic [INDEX_BITS-1:0] index;
		logic [CHAR_BITS-1:0]  key_char;
	} key_hit_t;

	// one result beat
	typedef struct packed {
		logic                  key_valid;
		logic [INDEX_BITS-1:0] key_index;
		logic [CHAR_BITS-1:0]  key_char;
	} key_result_t;

	localparam logic [CHAR_BITS-1:0] PAD_CHARS [PAD_SIZE][PAD_SIZE] = '{
		'{8'h31, 8'h32, 8'h33, 8'h41},
		'{8'h34, 8'h35, 8'h36, 8'h42},
		'{8'h37, 8'h38, 8'h39, 8'h43},
		'{8'h46, 8'h30, 8'h45, 8'h44}
	};

	function automatic logic [CHAR_BITS-1:0] pad_char(input logic [1:0] row,
			input logic [1:0] col);
		return PAD_CHARS[row][col];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/kds_scan_encode.sv
// priority encoder: first pressed key in scan order and its keymap code
`default_nettype none

module kds_scan_encode #(
	parameter int ROW_COUNT = 4,
	parameter int COL_COUNT = 4
) (
	input  wire logic [kds_pkg::SENSE_BITS-1:0] key_sense,
	output kds_pkg::key_hit_t                   hit
);

	always_comb begin
		int bit_pos;
		int kcol;
		int pos;
		int idx;
		hit = '0;
		// walk backwards so the earliest key in scan order wins
		for (int c = COL_COUNT - 1; c >= 0; c--) begin
			for (int r = ROW_COUNT - 1; r >= 0; r--) begin
				bit_pos = c * ROW_COUNT + r;
				kcol    = COL_COUNT - 1 - c;
				pos     = r * COL_COUNT + kcol + 1;
				idx     = r * kds_pkg::PAD_SIZE + kcol;
				if (bit_pos < kds_pkg::SENSE_BITS && key_sense[bit_pos[3:0]]) begin
					hit.found = 1'b1;
					hit.code  = pos[kds_pkg::CODE_BITS-1:0];
					hit.index = idx[kds_pkg::INDEX_BITS-1:0];
					if (r < kds_pkg::PAD_SIZE && kcol < kds_pkg::PAD_SIZE) begin
						hit.key_char = kds_pkg::pad_char(r[1:0], kcol[1:0]);
					end else begin
						hit.key_char = '0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/kds_debounce.sv
// debounce and repeat-wait decision with the held key and timestamp registers
`default_nettype none

module kds_debounce #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire kds_pkg::key_hit_t             hit,
	input  wire logic [TIME_BITS-1:0]          now,
	input  wire logic [kds_pkg::CFG_BITS-1:0]  debounce_ms,
	input  wire logic [kds_pkg::CFG_BITS-1:0]  repeat_wait_ms,
	output kds_pkg::key_result_t               result
);

	logic [kds_pkg::CODE_BITS-1:0] held_key_q;
	logic [TIME_BITS-1:0]          steady_since_q;
	logic [TIME_BITS-1:0]          last_report_q;

	logic                 same_key;
	logic [TIME_BITS-1:0] steady_eff;
	logic [TIME_BITS-1:0] steady_age;
	logic [TIME_BITS-1:0] report_gap;
	logic                 report;

	always_comb begin
		same_key   = (hit.code == held_key_q);
		steady_eff = same_key ? steady_since_q : now;
		// differences wrap at the timestamp width
		steady_age = now - steady_eff;
		report_gap = now - last_report_q;
		report     = hit.found
			&& (steady_age > TIME_BITS'(debounce_ms))
			&& (report_gap > TIME_BITS'(repeat_wait_ms));
		result           = '0;
		result.key_valid = report;
		if (report) begin
			result.key_index = hit.index;
			result.key_char  = hit.key_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_key_q     <= '0;
			steady_since_q <= '0;
			last_report_q  <= '0;
		end else if (advance) begin
			if (!hit.found) begin
				held_key_q <= '0;
			end else begin
				held_key_q <= hit.code;
				if (!same_key) begin
					steady_since_q <= now;
				end
				if (report) begin
					last_report_q <= now;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/matrix_keypad_debounce_scanner.sv
// matrix keypad scanner: throughput one beat per cycle unless out_ready stalls
// the full result register; input register, one pass of encode and
// debounce compare, then the result register that also acts as output buffer
// the debounce state updates in the same cycle the result register loads
// reset clears held key, both timestamps and the valid flags; registers
// return to debounce 50 ms and repeat wait 300 ms
`default_nettype none

module matrix_keypad_debounce_scanner #(
	parameter int ROW_COUNT = 4,
	parameter int COL_COUNT = 4,
	parameter int TIME_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [0:0]                        cfg_index,
	input  wire logic [kds_pkg::CFG_BITS-1:0]      cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [kds_pkg::SENSE_BITS-1:0]    key_sense,
	input  wire logic [31:0]                       time_ms,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   key_valid,
	output logic [kds_pkg::INDEX_BITS-1:0]         key_index,
	output logic [kds_pkg::CHAR_BITS-1:0]          key_char
);

	localparam int NOW_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;

	logic [kds_pkg::CFG_BITS-1:0]   debounce_q;
	logic [kds_pkg::CFG_BITS-1:0]   repeat_wait_q;

	logic                           valid_s1;
	logic [kds_pkg::SENSE_BITS-1:0] sense_s1;
	logic [TIME_BITS-1:0]           now_s1;

	logic                           valid_s2;
	kds_pkg::key_result_t           result_s2;

	logic                           advance;
	kds_pkg::key_hit_t              hit;
	kds_pkg::key_result_t           result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= kds_pkg::DEBOUNCE_RESET;
			repeat_wait_q <= kds_pkg::REPEAT_WAIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kds_pkg::REG_DEBOUNCE:    debounce_q    <= cfg_data;
				kds_pkg::REG_REPEAT_WAIT: repeat_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sense_s1 <= key_sense;
			now_s1   <= TIME_BITS'(time_ms[NOW_BITS-1:0]);
		end
	end

	kds_scan_encode #(
		.ROW_COUNT(ROW_COUNT),
		.COL_COUNT(COL_COUNT)
	) u_encode (
		.key_sense(sense_s1),
		.hit      (hit)
	);

	kds_debounce #(
		.TIME_BITS(TIME_BITS)
	) u_debounce (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.hit           (hit),
		.now           (now_s1),
		.debounce_ms   (debounce_q),
		.repeat_wait_ms(repeat_wait_q),
		.result        (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign key_valid = result_s2.key_valid;
	assign key_index = result_s2.key_index;
	assign key_char  = result_s2.key_char;

endmodule

`default_nettype wire
